@@ rtl/core/jec_pkg.sv @@
// Shared types and constants for the jerk event classifier.
// No dependencies.
package jec_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned AXIS_SQ_W  = 31;
    localparam int unsigned LEVEL_W    = 15;
    localparam int unsigned LEVEL_SQ_W = 30;
    localparam int unsigned MAG_W      = 32;
    localparam int unsigned CODE_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRASH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL  = 2'd2;

    localparam logic [LEVEL_W-1:0]    CRASH_RST     = 15'd150;
    localparam logic [LEVEL_W-1:0]    MOTION_RST    = 15'd50;
    localparam logic [LEVEL_W-1:0]    STILL_RST     = 15'd15;
    localparam logic [LEVEL_SQ_W-1:0] CRASH_SQ_RST  = 30'd22500;
    localparam logic [LEVEL_SQ_W-1:0] MOTION_SQ_RST = 30'd2500;
    localparam logic [LEVEL_SQ_W-1:0] STILL_SQ_RST  = 30'd225;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE     = 3'd0,
        EV_SHAKE    = 3'd1,
        EV_WRECK    = 3'd2,
        EV_SPEEDING = 3'd3,
        EV_DECEL    = 3'd4
    } t_event;

    // per-item features handed from the square stage to the decision stage
    typedef struct packed {
        logic [AXIS_SQ_W-1:0] sq_x;
        logic [AXIS_SQ_W-1:0] sq_y;
        logic [AXIS_SQ_W-1:0] sq_z;
        logic                 moved;
    } t_feat;

endpackage

@@ rtl/core/jec_feature.sv @@
// Square of each axis and per-axis change test against the previous sample.
// Depends on jec_pkg.
module jec_feature
    import jec_pkg::*;
(
    input  logic signed [AXIS_W-1:0]  i_x,
    input  logic signed [AXIS_W-1:0]  i_y,
    input  logic signed [AXIS_W-1:0]  i_z,
    input  logic signed [AXIS_W-1:0]  i_prev_x,
    input  logic signed [AXIS_W-1:0]  i_prev_y,
    input  logic signed [AXIS_W-1:0]  i_prev_z,
    input  logic        [LEVEL_W-1:0] i_motion_level,
    output t_feat                     o_feat
);

    logic signed [2*AXIS_W-1:0] prod_x;
    logic signed [2*AXIS_W-1:0] prod_y;
    logic signed [2*AXIS_W-1:0] prod_z;
    logic signed [AXIS_W:0]     diff_x;
    logic signed [AXIS_W:0]     diff_y;
    logic signed [AXIS_W:0]     diff_z;
    logic        [AXIS_W:0]     abs_x;
    logic        [AXIS_W:0]     abs_y;
    logic        [AXIS_W:0]     abs_z;
    logic        [AXIS_W:0]     motion_ext;

    assign prod_x = (2*AXIS_W)'(i_x) * (2*AXIS_W)'(i_x);
    assign prod_y = (2*AXIS_W)'(i_y) * (2*AXIS_W)'(i_y);
    assign prod_z = (2*AXIS_W)'(i_z) * (2*AXIS_W)'(i_z);

    assign diff_x = {i_x[AXIS_W-1], i_x} - {i_prev_x[AXIS_W-1], i_prev_x};
    assign diff_y = {i_y[AXIS_W-1], i_y} - {i_prev_y[AXIS_W-1], i_prev_y};
    assign diff_z = {i_z[AXIS_W-1], i_z} - {i_prev_z[AXIS_W-1], i_prev_z};

    // magnitude of a 17-bit difference never exceeds 65535, so it fits unsigned
    assign abs_x = diff_x[AXIS_W] ? 17'(-diff_x) : 17'(diff_x);
    assign abs_y = diff_y[AXIS_W] ? 17'(-diff_y) : 17'(diff_y);
    assign abs_z = diff_z[AXIS_W] ? 17'(-diff_z) : 17'(diff_z);

    assign motion_ext = {2'b00, i_motion_level};

    always_comb begin
        o_feat.sq_x  = prod_x[AXIS_SQ_W-1:0];
        o_feat.sq_y  = prod_y[AXIS_SQ_W-1:0];
        o_feat.sq_z  = prod_z[AXIS_SQ_W-1:0];
        o_feat.moved = (abs_x > motion_ext) || (abs_y > motion_ext) || (abs_z > motion_ext);
    end

endmodule

@@ rtl/core/jec_decide.sv @@
// Magnitude sum and prioritized event decision.
// Depends on jec_pkg.
module jec_decide
    import jec_pkg::*;
(
    input  t_feat                    i_feat,
    input  logic [MAG_W-1:0]         i_older_mag,
    input  logic [MAG_W-1:0]         i_prior_mag,
    input  logic [LEVEL_SQ_W-1:0]    i_crash_sq,
    input  logic [LEVEL_SQ_W-1:0]    i_motion_sq,
    input  logic [LEVEL_SQ_W-1:0]    i_still_sq,
    output logic [MAG_W-1:0]         o_mag,
    output t_event                   o_code
);

    logic [MAG_W-1:0] crash_ext;
    logic [MAG_W-1:0] motion_ext;
    logic [MAG_W-1:0] still_ext;
    logic             cur_crash;

    // three squares of at most 2^30 each stay below 2^32
    assign o_mag = MAG_W'(i_feat.sq_x) + MAG_W'(i_feat.sq_y) + MAG_W'(i_feat.sq_z);

    assign crash_ext  = MAG_W'(i_crash_sq);
    assign motion_ext = MAG_W'(i_motion_sq);
    assign still_ext  = MAG_W'(i_still_sq);
    assign cur_crash  = (o_mag >= crash_ext);

    always_comb begin
        if (cur_crash && (i_older_mag >= crash_ext) && (i_prior_mag >= crash_ext)) begin
            o_code = EV_WRECK;
        end else if (cur_crash) begin
            o_code = EV_SHAKE;
        end else if ((o_mag >= motion_ext) && i_feat.moved) begin
            o_code = EV_SPEEDING;
        end else if (o_mag < still_ext) begin
            o_code = EV_DECEL;
        end else begin
            o_code = EV_NONE;
        end
    end

endmodule

@@ rtl/core/jerk_event_classifier_top.sv @@
// Jerk event classifier: input register, one combinational pass (squares, decision),
// result register.
// An item moves on to the output register once the result register is empty or being taken;
// throughput 1 item per cycle while the output is not stalled.
// The input register refills when it is empty or the result register empties or is being taken, so a
// stalled result stops input only once both registers are full.
// Reset (synchronous, active low) empties both registers, zeroes history, loads default levels.
// Depends on jec_pkg, jec_feature, jec_decide.
module jerk_event_classifier_top
    import jec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // jerk_x[15:0], jerk_y[31:16], jerk_z[47:32]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata   // event_code[2:0], magnitude_sq[34:3], zero pad
);

    logic [LEVEL_W-1:0]    r_crash_level;
    logic [LEVEL_W-1:0]    r_motion_level;
    logic [LEVEL_W-1:0]    r_still_level;
    logic [LEVEL_SQ_W-1:0] r_crash_sq;
    logic [LEVEL_SQ_W-1:0] r_motion_sq;
    logic [LEVEL_SQ_W-1:0] r_still_sq;

    logic                     r_in_valid;
    logic signed [AXIS_W-1:0] r_in_x;
    logic signed [AXIS_W-1:0] r_in_y;
    logic signed [AXIS_W-1:0] r_in_z;
    logic signed [AXIS_W-1:0] r_prev_x;
    logic signed [AXIS_W-1:0] r_prev_y;
    logic signed [AXIS_W-1:0] r_prev_z;

    t_feat feat;

    logic [MAG_W-1:0] r_older_mag;
    logic [MAG_W-1:0] r_prior_mag;

    logic             r_out_valid;
    t_event           r_out_code;
    logic [MAG_W-1:0] r_out_mag;
    t_event           n_out_code;
    logic [MAG_W-1:0] n_out_mag;

    logic in_ready;
    logic out_ready;
    logic in_fire;
    logic out_load;

    assign out_ready = !r_out_valid || m_axis_tready;
    assign in_ready  = !r_in_valid || out_ready;
    assign in_fire   = s_axis_tvalid && in_ready;
    assign out_load  = r_in_valid && out_ready;

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_mag, r_out_code};

    // configuration; squared levels are registered from the level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crash_level  <= CRASH_RST;
            r_motion_level <= MOTION_RST;
            r_still_level  <= STILL_RST;
            r_crash_sq     <= CRASH_SQ_RST;
            r_motion_sq    <= MOTION_SQ_RST;
            r_still_sq     <= STILL_SQ_RST;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CRASH:  r_crash_level  <= i_cfg_wdata;
                    CFG_MOTION: r_motion_level <= i_cfg_wdata;
                    CFG_STILL:  r_still_level  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_crash_sq  <= LEVEL_SQ_W'(r_crash_level) * LEVEL_SQ_W'(r_crash_level);
            r_motion_sq <= LEVEL_SQ_W'(r_motion_level) * LEVEL_SQ_W'(r_motion_level);
            r_still_sq  <= LEVEL_SQ_W'(r_still_level) * LEVEL_SQ_W'(r_still_level);
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_x <= s_axis_tdata[15:0];
            r_in_y <= s_axis_tdata[31:16];
            r_in_z <= s_axis_tdata[47:32];
        end
    end

    jec_feature u_feature (
        .i_x            (r_in_x),
        .i_y            (r_in_y),
        .i_z            (r_in_z),
        .i_prev_x       (r_prev_x),
        .i_prev_y       (r_prev_y),
        .i_prev_z       (r_prev_z),
        .i_motion_level (r_motion_level),
        .o_feat         (feat)
    );

    jec_decide u_decide (
        .i_feat      (feat),
        .i_older_mag (r_older_mag),
        .i_prior_mag (r_prior_mag),
        .i_crash_sq  (r_crash_sq),
        .i_motion_sq (r_motion_sq),
        .i_still_sq  (r_still_sq),
        .o_mag       (n_out_mag),
        .o_code      (n_out_code)
    );

    // result stage; axis and magnitude history shift with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_older_mag <= '0;
            r_prior_mag <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_older_mag <= r_prior_mag;
                r_prior_mag <= n_out_mag;
                r_prev_x    <= r_in_x;
                r_prev_y    <= r_in_y;
                r_prev_z    <= r_in_z;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_code <= n_out_code;
            r_out_mag  <= n_out_mag;
        end
    end

    // a stalled result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // history shifts when an item enters the result register
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_older_mag == $past(r_prior_mag)) && (r_prior_mag == r_out_mag))
        else $error("magnitude history out of step with results");

    // an empty input register always takes the next item
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule
